@@ rtl/piecewise_linear_interpolator_defines.svh @@
// Assertion macros shared by the interpolator RTL
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/pli_pkg.sv @@
// Shared constants, codes and interface structs of the interpolator
package pli_pkg;

	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int DATA_W     = 32;
	localparam int DIFF_W     = DATA_W + 1;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int NUM_W      = PROD_W + 1;
	// quotient bits kept; anything at or above 2^Q_W saturates the result anyway
	localparam int Q_W        = 41;
	localparam int QCNT_W     = $clog2(Q_W);
	localparam int SUM_W      = Q_W + 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [1:0] ST_INTERIOR = 2'd0;
	localparam logic [1:0] ST_EXT_LO   = 2'd1;
	localparam logic [1:0] ST_EXT_HI   = 2'd2;
	localparam logic [1:0] ST_ZERO_W   = 2'd3;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
	} tbl_wr_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] rem_init;
		logic [Q_W-1:0]    num_lo;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

endpackage

@@ rtl/pli_table.sv @@
// Breakpoint x/y memories: one write port, one registered read port
module pli_table (
	input  logic                        clk,
	input  pli_pkg::tbl_wr_t            wr,
	input  logic [pli_pkg::ADDR_W-1:0]  rd_addr,
	output logic [pli_pkg::DATA_W-1:0]  rd_x,
	output logic [pli_pkg::DATA_W-1:0]  rd_y
);
	import pli_pkg::*;

	logic [DATA_W-1:0] x_mem [MAX_POINTS];
	logic [DATA_W-1:0] y_mem [MAX_POINTS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			x_mem[wr.addr] <= wr.x;
			y_mem[wr.addr] <= wr.y;
		end
	end

	always_ff @(posedge clk) begin
		rd_x <= x_mem[rd_addr];
		rd_y <= y_mem[rd_addr];
	end

endmodule

@@ rtl/pli_divider.sv @@
// Restoring divider, one quotient bit per cycle
`include "piecewise_linear_interpolator_defines.svh"

module pli_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pli_pkg::div_req_t       req,
	output logic                    done,
	output logic [pli_pkg::Q_W-1:0] quotient
);
	import pli_pkg::*;

	logic              running_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [Q_W-1:0]    quo_q;
	logic [DATA_W-1:0] divisor_q;

	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   trial_sub;
	logic              ge;

	// shift the next numerator bit into the partial remainder
	assign trial     = {rem_q, quo_q[Q_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};
	assign ge        = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			done_q <= running_q && !req.start && (cnt_q == QCNT_W'(Q_W - 1));
			if (req.start) begin
				running_q <= 1'b1;
				cnt_q     <= '0;
			end else if (running_q) begin
				cnt_q <= cnt_q + QCNT_W'(1);
				if (cnt_q == QCNT_W'(Q_W - 1))
					running_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q     <= req.rem_init;
			quo_q     <= req.num_lo;
			divisor_q <= req.divisor;
		end else if (running_q) begin
			rem_q <= ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`PLI_ASSERT_NEXT(a_start_runs, clk, arst_n, req.start, running_q, "divider did not start")
	`PLI_ASSERT_NOW(a_rem_below, clk, arst_n, running_q, rem_q < divisor_q, "remainder overflow")
	`PLI_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, !running_q, "done while still running")

endmodule

@@ rtl/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator: sequencer, search, multiply, divide and result stage
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_data) sets point_count; always ready.
//    Write it only while the block is idle.
//  - in channel (in_valid/in_stall): operation 0 loads x_value/y_value into entry
//    point_index and yields no result; operation 1 queries x_value.
//  - out channel (out_valid/out_stall) carries result_y, status and saturated.
//  - A query runs a sequencer over one table read port: two bound checks, a forward
//    segment walk of one entry per cycle from the kept search pointer, two endpoint
//    fetches, one 32x32 multiply and a one-bit-per-cycle divider. A zero-width
//    segment skips multiply and divider, a quotient overflow skips the divider,
//    and a query outside the table skips the walk; below the table it also skips
//    the upper bound check.
//  - in_stall is high while a query is in flight; the next item can transfer the
//    cycle the result appears. A held result does not block the next input, but a
//    finished query waits while the previous result is stalled.
//  - Reset clears the pointer, sets point_count to 2 and empties the output;
//    table contents are undefined until loaded.
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pli_pkg::CNT_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [pli_pkg::ADDR_W-1:0]    point_index,
	input  logic signed [pli_pkg::DATA_W-1:0] x_value,
	input  logic signed [pli_pkg::DATA_W-1:0] y_value,
	input  logic                          start_of_run,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [pli_pkg::DATA_W-1:0] result_y,
	output logic [1:0]                    status,
	output logic                          saturated
);
	import pli_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE    = 11'b000_0000_0001,
		S_CHK_LO  = 11'b000_0000_0010,
		S_CHK_HI  = 11'b000_0000_0100,
		S_WALK    = 11'b000_0000_1000,
		S_FETCH_L = 11'b000_0001_0000,
		S_FETCH_R = 11'b000_0010_0000,
		S_DIFF    = 11'b000_0100_0000,
		S_MUL     = 11'b000_1000_0000,
		S_NORM    = 11'b001_0000_0000,
		S_DIV     = 11'b010_0000_0000,
		S_FINISH  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]  point_count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  i_q;
	logic [ADDR_W-1:0] lo_q;
	logic [1:0]        stat_q;
	logic              zero_q;
	logic              ovf_q;
	logic              neg_q;
	logic signed [DATA_W-1:0] x_q;
	logic [DATA_W-1:0] x0_q;
	logic [DATA_W-1:0] y0_q;
	logic [DATA_W-1:0] adx_q;
	logic [DATA_W-1:0] mdy_q;
	logic [DATA_W-1:0] mdq_q;
	logic [PROD_W-1:0] prod_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] result_q;
	logic [1:0]        status_q;
	logic              saturated_q;

	logic              in_acc;
	logic              out_free;
	logic [CNT_W-1:0]  n_used;
	logic [CNT_W-1:0]  n_m1;
	logic [CNT_W-1:0]  n_m2;
	logic [CNT_W-1:0]  i_clamp;
	logic [CNT_W-1:0]  i_inc;
	logic [CNT_W-1:0]  i_fix;
	logic [CNT_W-1:0]  i_dec;
	logic [ADDR_W-1:0] lo_inc;
	logic [ADDR_W-1:0] rd_addr;
	logic [DATA_W-1:0] rd_x;
	logic [DATA_W-1:0] rd_y;
	logic              walk_more;

	logic [DIFF_W-1:0] dx;
	logic [DIFF_W-1:0] dy;
	logic [DIFF_W-1:0] dq;
	logic [DIFF_W-1:0] adx;
	logic [DIFF_W-1:0] ady;
	logic [DIFF_W-1:0] adq;

	logic [NUM_W-1:0]  num;
	logic [DATA_W-1:0] num_hi;
	logic              ovf;

	logic [SUM_W-1:0]  y_ext;
	logic [SUM_W-1:0]  q_ext;
	logic [SUM_W-1:0]  sum;
	logic [SUM_W-DATA_W:0] sum_top;
	logic              sum_fits;
	logic [DATA_W-1:0] fin_y;
	logic [1:0]        fin_st;
	logic              fin_sat;

	tbl_wr_t           tbl_wr;
	div_req_t          div_req;
	logic              div_done;
	logic [Q_W-1:0]    quotient;

	assign cfg_ready = 1'b1;
	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		if (point_count_q < CNT_W'(2))
			n_used = CNT_W'(2);
		else if (point_count_q > CNT_W'(MAX_POINTS))
			n_used = CNT_W'(MAX_POINTS);
		else
			n_used = point_count_q;
	end

	assign n_m1      = n_q - CNT_W'(1);
	assign n_m2      = n_q - CNT_W'(2);
	assign i_clamp   = (ptr_q > n_m1) ? n_m1 : ptr_q;
	assign i_inc     = i_q + CNT_W'(1);
	assign i_fix     = (i_q < CNT_W'(1)) ? CNT_W'(1) : i_q;
	assign i_dec     = i_fix - CNT_W'(1);
	assign lo_inc    = lo_q + ADDR_W'(1);
	assign walk_more = (i_q < n_m1) && (x_q >= $signed(rd_x));

	always_comb begin
		unique case (state_q)
			S_CHK_LO:  rd_addr = n_m1[ADDR_W-1:0];
			S_CHK_HI:  rd_addr = i_clamp[ADDR_W-1:0];
			S_WALK:    rd_addr = i_inc[ADDR_W-1:0];
			S_FETCH_L: rd_addr = lo_q;
			S_FETCH_R: rd_addr = lo_inc;
			default:   rd_addr = '0;
		endcase
	end

	assign tbl_wr.en   = in_acc && (operation == OP_LOAD);
	assign tbl_wr.addr = point_index;
	assign tbl_wr.x    = x_value;
	assign tbl_wr.y    = y_value;

	pli_table u_table (
		.clk     (clk),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_x    (rd_x),
		.rd_y    (rd_y)
	);

	// in S_DIFF the read port holds the right endpoint
	assign dx  = {rd_x[DATA_W-1], rd_x} - {x0_q[DATA_W-1], x0_q};
	assign dy  = {rd_y[DATA_W-1], rd_y} - {y0_q[DATA_W-1], y0_q};
	assign dq  = {x_q[DATA_W-1], x_q} - {x0_q[DATA_W-1], x0_q};
	assign adx = dx[DIFF_W-1] ? -dx : dx;
	assign ady = dy[DIFF_W-1] ? -dy : dy;
	assign adq = dq[DIFF_W-1] ? -dq : dq;

	// round half away: add half the divisor before dividing
	assign num    = {1'b0, prod_q} + NUM_W'(adx_q[DATA_W-1:1]);
	assign num_hi = DATA_W'(num[NUM_W-1:Q_W]);
	assign ovf    = num_hi >= adx_q;

	assign div_req.start    = (state_q == S_NORM) && !ovf;
	assign div_req.rem_init = num_hi;
	assign div_req.num_lo   = num[Q_W-1:0];
	assign div_req.divisor  = adx_q;

	pli_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (quotient)
	);

	assign y_ext    = {{(SUM_W-DATA_W){y0_q[DATA_W-1]}}, y0_q};
	assign q_ext    = SUM_W'(quotient);
	assign sum      = neg_q ? (y_ext - q_ext) : (y_ext + q_ext);
	assign sum_top  = sum[SUM_W-1:DATA_W-1];
	assign sum_fits = (sum_top == '0) || (sum_top == '1);

	always_comb begin
		fin_st  = stat_q;
		fin_sat = 1'b0;
		fin_y   = sum[DATA_W-1:0];
		if (zero_q) begin
			fin_st = ST_ZERO_W;
			fin_y  = y0_q;
		end else if (ovf_q || !sum_fits) begin
			fin_sat = 1'b1;
			if (ovf_q ? neg_q : sum[SUM_W-1])
				fin_y = {1'b1, {(DATA_W-1){1'b0}}};
			else
				fin_y = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			point_count_q <= CNT_W'(2);
			ptr_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				point_count_q <= cfg_data;
			// raise on a finished query, drop once the held result transfers
			if ((state_q == S_FINISH) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (operation == OP_QUERY)) begin
						if (start_of_run)
							ptr_q <= '0;
						state_q <= S_CHK_LO;
					end
				end
				S_CHK_LO: begin
					if (x_q < $signed(rd_x))
						state_q <= S_FETCH_L;
					else
						state_q <= S_CHK_HI;
				end
				S_CHK_HI: begin
					if (x_q >= $signed(rd_x))
						state_q <= S_FETCH_L;
					else
						state_q <= S_WALK;
				end
				S_WALK: begin
					if (!walk_more) begin
						ptr_q   <= i_fix;
						state_q <= S_FETCH_L;
					end
				end
				S_FETCH_L: state_q <= S_FETCH_R;
				S_FETCH_R: state_q <= S_DIFF;
				S_DIFF: begin
					if (dx == '0)
						state_q <= S_FINISH;
					else
						state_q <= S_MUL;
				end
				S_MUL:  state_q <= S_NORM;
				S_NORM: state_q <= ovf ? S_FINISH : S_DIV;
				S_DIV: begin
					if (div_done)
						state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				x_q    <= x_value;
				n_q    <= n_used;
				zero_q <= 1'b0;
				ovf_q  <= 1'b0;
			end
			S_CHK_LO: begin
				lo_q   <= '0;
				stat_q <= ST_EXT_LO;
			end
			S_CHK_HI: begin
				lo_q   <= n_m2[ADDR_W-1:0];
				stat_q <= ST_EXT_HI;
				i_q    <= i_clamp;
			end
			S_WALK: begin
				if (walk_more) begin
					i_q <= i_inc;
				end else begin
					lo_q   <= i_dec[ADDR_W-1:0];
					stat_q <= ST_INTERIOR;
				end
			end
			S_FETCH_R: begin
				x0_q <= rd_x;
				y0_q <= rd_y;
			end
			S_DIFF: begin
				zero_q <= dx == '0;
				adx_q  <= adx[DATA_W-1:0];
				mdy_q  <= ady[DATA_W-1:0];
				mdq_q  <= adq[DATA_W-1:0];
				neg_q  <= dy[DIFF_W-1] ^ dq[DIFF_W-1] ^ dx[DIFF_W-1];
			end
			S_MUL:  prod_q <= mdy_q * mdq_q;
			S_NORM: ovf_q  <= ovf;
			S_FINISH: begin
				if (out_free) begin
					result_q    <= fin_y;
					status_q    <= fin_st;
					saturated_q <= fin_sat;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign result_y  = result_q;
	assign status    = status_q;
	assign saturated = saturated_q;

	`PLI_ASSERT_NOW(a_ptr_in_table, clk, arst_n, 1'b1,
		ptr_q < CNT_W'(MAX_POINTS), "pointer past table")
	`PLI_ASSERT_NOW(a_walk_bound, clk, arst_n, state_q == S_WALK,
		i_q < n_q, "walk passed last point")
	`PLI_ASSERT_NOW(a_zero_w_clean, clk, arst_n, out_valid_q && (status_q == ST_ZERO_W),
		!saturated_q, "zero-width result flagged saturated")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the piecewise linear interpolator
`timescale 1ns / 100ps

module tb_top;
	import pli_pkg::*;

	localparam int     IDLE_PCT          = 8;
	localparam int     SETTLE_CYCLES     = 160;
	localparam int     N_DIR             = 25;
	localparam int     N_PHASES          = 14;
	localparam int     QUERIES_PER_PHASE = 70;
	localparam longint TIMEOUT_NS        = 64'd40_000_000;
	localparam longint Y_MAX             = 64'sd2147483647;
	localparam longint Y_MIN             = -Y_MAX - 1;

	typedef struct packed {
		logic signed [DATA_W-1:0] y;
		logic [1:0]               st;
		logic                     sat;
	} interp_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] idx;
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic              sor;
		logic              typed;
		interp_t           want;
	} dir_row_t;

	typedef enum int {TBL_SMOOTH, TBL_WIDE, TBL_FLAT_SPOTS, TBL_SCRAMBLED} table_shape_t;

	logic                     clk;
	logic                     arst_n       = 1'b0;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CNT_W-1:0]         cfg_data     = '0;
	logic                     in_valid     = 1'b0;
	logic                     in_stall;
	logic                     operation    = OP_LOAD;
	logic [ADDR_W-1:0]        point_index  = '0;
	logic signed [DATA_W-1:0] x_value      = '0;
	logic signed [DATA_W-1:0] y_value      = '0;
	logic                     start_of_run = 1'b0;
	logic                     out_valid;
	logic                     out_stall    = 1'b0;
	logic signed [DATA_W-1:0] result_y;
	logic [1:0]               status;
	logic                     saturated;

	// predictor state
	logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
	logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
	logic [CNT_W-1:0]         walk_ptr  = '0;
	logic [CNT_W-1:0]         count_reg = CNT_W'(2);

	interp_t pending_interp [$];
	logic    idle_on    = 1'b1;
	int      fail_count = 0;
	int      n_checked  = 0;
	int      n_loads    = 0;
	int      n_queries  = 0;
	int      n_clipped  = 0;
	int      status_tally [4] = '{0, 0, 0, 0};

	dir_row_t dir_rows [N_DIR] = '{
		'{OP_LOAD,  6'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
		'{OP_LOAD,  6'd1,  32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0000_8000, 32'h0000_0000, 1'b1, 1'b1,
			'{32'h0001_0000, ST_INTERIOR, 1'b0}},
		'{OP_QUERY, 6'd63, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1,
			'{32'h0000_0000, ST_INTERIOR, 1'b0}},
		'{OP_QUERY, 6'd0,  32'h0001_0000, 32'h0000_0000, 1'b0, 1'b1,
			'{32'h0002_0000, ST_EXT_HI, 1'b0}},
		'{OP_QUERY, 6'd0,  32'hFFFF_0000, 32'h0000_0000, 1'b0, 1'b1,
			'{32'hFFFE_0000, ST_EXT_LO, 1'b0}},
		'{OP_QUERY, 6'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1,
			'{32'h8000_0000, ST_EXT_LO, 1'b1}},
		'{OP_QUERY, 6'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
			'{32'h7FFF_FFFF, ST_EXT_HI, 1'b1}},
		// exact halves round away from zero, both signs
		'{OP_LOAD,  6'd1,  32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0, '0},
		'{OP_QUERY, 6'd5,  32'h0000_0001, 32'h1234_5678, 1'b0, 1'b0, '0},
		'{OP_LOAD,  6'd1,  32'h0000_0002, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, '0},
		// zero-width segment wins over both extrapolation sides
		'{OP_LOAD,  6'd1,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0000_1234, 32'h0000_0000, 1'b0, 1'b1,
			'{32'h0000_0000, ST_ZERO_W, 1'b0}},
		'{OP_QUERY, 6'd0,  32'hFFFF_FFFB, 32'h0000_0000, 1'b1, 1'b1,
			'{32'h0000_0000, ST_ZERO_W, 1'b0}},
		// full-scale segment
		'{OP_LOAD,  6'd0,  32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, '0},
		'{OP_LOAD,  6'd1,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
			'{32'h7FFF_FFFF, ST_EXT_HI, 1'b0}},
		'{OP_QUERY, 6'd0,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1,
			'{32'h8000_0000, ST_INTERIOR, 1'b0}},
		// table with x going down
		'{OP_LOAD,  6'd0,  32'h0005_0000, 32'h0001_0000, 1'b0, 1'b0, '0},
		'{OP_LOAD,  6'd1,  32'hFFFF_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '0},
		'{OP_QUERY, 6'd0,  32'h0008_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
		'{OP_LOAD,  6'd63, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, '0}
	};

	int count_plan [N_PHASES] = '{64, 2, 17, 0, 64, 1, 127, 5, 65, 40, -1, -1, 3, 64};

	piecewise_linear_interpolator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.point_index  (point_index),
		.x_value      (x_value),
		.y_value      (y_value),
		.start_of_run (start_of_run),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_y     (result_y),
		.status       (status),
		.saturated    (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timed out with %0d results outstanding", pending_interp.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Interpolate one query point against the current table; advances the walk pointer.
	function automatic interp_t interpolate(logic signed [DATA_W-1:0] qx, logic restart);
		int unsigned n, lo, i;
		logic [1:0]  st;
		longint      x0, x1, y0, y1, dx, dy, dq, r;
		logic [65:0] adx, mdy, mdq, prod, q;
		logic        neg;
		interp_t     res;
		n = (count_reg < 2) ? 2 : ((count_reg > MAX_POINTS) ? MAX_POINTS : count_reg);
		if (restart)
			walk_ptr = '0;
		if (qx < bp_x[0]) begin
			lo = 0;
			st = ST_EXT_LO;
		end else if (qx >= bp_x[n-1]) begin
			lo = n - 2;
			st = ST_EXT_HI;
		end else begin
			i = 32'(walk_ptr);
			if (i > n - 1)
				i = n - 1;
			while (i < n - 1 && qx >= bp_x[i])
				i++;
			if (i < 1)
				i = 1;
			walk_ptr = CNT_W'(i);
			lo = i - 1;
			st = ST_INTERIOR;
		end
		x0 = bp_x[lo];
		x1 = bp_x[lo+1];
		y0 = bp_y[lo];
		y1 = bp_y[lo+1];
		dx = x1 - x0;
		res.sat = 1'b0;
		if (dx == 0) begin
			r  = y0;
			st = ST_ZERO_W;
		end else begin
			dy   = y1 - y0;
			dq   = qx - x0;
			neg  = ((dy < 0) != (dq < 0)) != (dx < 0);
			adx  = (dx < 0) ? -dx : dx;
			mdy  = (dy < 0) ? -dy : dy;
			mdq  = (dq < 0) ? -dq : dq;
			prod = mdy * mdq;
			q    = (prod + adx / 2) / adx;
			if (q > (66'd1 << 40))
				q = 66'd1 << 40;
			r = y0 + (neg ? -longint'(q) : longint'(q));
			if (r > Y_MAX) begin
				r       = Y_MAX;
				res.sat = 1'b1;
			end else if (r < Y_MIN) begin
				r       = Y_MIN;
				res.sat = 1'b1;
			end
		end
		res.y  = r[DATA_W-1:0];
		res.st = st;
		return res;
	endfunction

	function automatic logic signed [DATA_W-1:0] clip32(longint v);
		return (v > Y_MAX) ? 32'h7FFF_FFFF : ((v < Y_MIN) ? 32'h8000_0000 : v[DATA_W-1:0]);
	endfunction

	function automatic longint unsigned rand64();
		return {$urandom, $urandom};
	endfunction

	// Present one item, hold it through stalls, and update the predictor on transfer.
	task automatic send_item(input logic op, input logic [ADDR_W-1:0] idx,
			input logic signed [DATA_W-1:0] xv, input logic signed [DATA_W-1:0] yv,
			input logic sor, input logic typed, input interp_t want);
		interp_t pred;
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		point_index  <= idx;
		x_value      <= xv;
		y_value      <= yv;
		start_of_run <= sor;
		do @(posedge clk); while (in_stall);
		if (op == OP_LOAD) begin
			bp_x[idx] = xv;
			bp_y[idx] = yv;
			n_loads++;
		end else begin
			pred = interpolate(xv, sor);
			pending_interp.insert(pending_interp.size(), typed ? want : pred);
			n_queries++;
		end
	endtask

	// Drain all outstanding results, then give a trailing load or walk time to finish.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_interp.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input logic [CNT_W-1:0] cv);
		cfg_valid <= 1'b1;
		cfg_data  <= cv;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		count_reg = cv;
	endtask

	task automatic run_phase(input int cval, input bit fill_all);
		table_shape_t      shape;
		int                sel, nu, n_fill;
		longint            xv, yv, step, lo, hi, span, seg, cand, last_x;
		longint unsigned   width, wstep;
		logic              sor;
		nu     = (cval < 2) ? 2 : ((cval > MAX_POINTS) ? MAX_POINTS : cval);
		n_fill = fill_all ? MAX_POINTS : nu;
		sel    = $urandom_range(99);
		shape  = (sel < 55) ? TBL_SMOOTH : (sel < 75) ? TBL_WIDE :
			(sel < 88) ? TBL_FLAT_SPOTS : TBL_SCRAMBLED;
		xv = (shape == TBL_WIDE) ? Y_MIN + longint'($urandom_range(0, 1 << 30)) :
			longint'($urandom_range(0, 1 << 21)) - (1 << 20);
		for (int k = 0; k < n_fill; k++) begin
			case (shape)
				TBL_SMOOTH: begin
					step = $urandom_range(1, 1 << 18);
					yv   = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
				end
				TBL_WIDE: begin
					step = $urandom_range(1, 1 << 25);
					yv   = longint'(int'($urandom));
				end
				TBL_FLAT_SPOTS: begin
					step = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 1 << 18);
					yv   = longint'(int'($urandom));
				end
				default: begin
					xv   = longint'(int'($urandom));
					step = 0;
					yv   = longint'(int'($urandom));
				end
			endcase
			send_item(OP_LOAD, ADDR_W'(k), clip32(xv), clip32(yv),
				1'($urandom_range(1)), 1'b0, '0);
			xv += step;
		end

		lo = bp_x[0];
		hi = bp_x[nu-1];
		span = hi - lo;
		if (span <= 0)
			span = 1 << 20;
		seg    = span / nu;
		width  = span * 5 / 4 + 1;
		wstep  = 2 * seg + 2;
		last_x = lo;
		for (int q = 0; q < QUERIES_PER_PHASE; q++) begin
			// occasional rewrite inside the active range breaks ordering mid-run
			if ($urandom_range(99) < 4)
				send_item(OP_LOAD, ADDR_W'($urandom_range(nu - 1)), $urandom, $urandom,
					1'($urandom_range(1)), 1'b0, '0);
			sel = $urandom_range(99);
			if (sel < 5) begin
				cand = longint'(int'($urandom));
				sor  = 1'($urandom_range(1));
			end else if (sel < 20) begin
				cand = lo - span / 8 + longint'(rand64() % width);
				sor  = 1'($urandom_range(1));
			end else begin
				cand = last_x + longint'(rand64() % wstep);
				sor  = ($urandom_range(99) < 4);
				if (cand > hi + seg) begin
					cand = lo;
					sor  = 1'b1;
				end
			end
			last_x = cand;
			send_item(OP_QUERY, ADDR_W'($urandom_range(MAX_POINTS - 1)), clip32(cand),
				$urandom, sor, 1'b0, '0);
		end
	endtask

	always @(posedge clk) begin
		out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		interp_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_interp.size() == 0) begin
				if (fail_count < 10)
					$display("Unexpected result at %0t: result_y %h status %0d sat %0d",
						$time, result_y, status, saturated);
				fail_count++;
			end else begin
				exp_res = pending_interp.pop_front();
				n_checked++;
				status_tally[exp_res.st]++;
				if (exp_res.sat)
					n_clipped++;
				if (result_y !== exp_res.y || status !== exp_res.st
						|| saturated !== exp_res.sat) begin
					if (fail_count < 10)
						$display({"Mismatch at %0t: result_y %h/%h status %0d/%0d ",
							"saturated %0d/%0d (expected/actual)"},
							$time, exp_res.y, result_y, exp_res.st, status, exp_res.sat,
							saturated);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int cv;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run at the reset point count of two
		for (int k = 0; k < N_DIR; k++)
			send_item(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].x, dir_rows[k].y,
				dir_rows[k].sor, dir_rows[k].typed, dir_rows[k].want);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			quiesce();
			// no idling on either side for a stretch of phases
			idle_on <= !(ph >= 4 && ph <= 6);
			cv = (count_plan[ph] < 0) ? $urandom_range(2, MAX_POINTS) : count_plan[ph];
			write_count(CNT_W'(cv));
			run_phase(cv, ph == 0);
		end

		quiesce();
		$display("Checked %0d results from %0d loads and %0d queries over %0d point counts",
			n_checked, n_loads, n_queries, N_PHASES + 1);
		$display("Status interior/low/high/zero-width: %0d/%0d/%0d/%0d, clipped %0d",
			status_tally[0], status_tally[1], status_tally[2], status_tally[3], n_clipped);
		$display("Errors: %0d", fail_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
